[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent checks, compiled out for synthesis.
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif

`endif

[design/drse_pkg.sv]
package drse_pkg;

  localparam int unsigned SpeedW = 7;
  localparam int unsigned AngleW = 8;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned PulseW = 12;
  localparam int unsigned CfgW   = 8;

  localparam logic [SpeedW-1:0] SPEED_MAX = 7'd100;
  localparam logic [AngleW-1:0] ANGLE_MAX = 8'd180;
  localparam logic [PulseW-1:0] PULSE_BASE = 12'd500;

  // floor(v*255/100) = (v*DUTY_MUL) >> DUTY_SHIFT for v in 0..100
  localparam logic [20:0] DUTY_MUL   = 21'd1336965;
  localparam int unsigned DUTY_SHIFT = 19;
  // floor(a*2000/180) = (a*PULSE_MUL) >> PULSE_SHIFT for a in 0..180
  localparam logic [19:0] PULSE_MUL   = 20'd728178;
  localparam int unsigned PULSE_SHIFT = 16;

  localparam logic [SpeedW-1:0] SPEED_RST = 7'd0;
  localparam logic [AngleW-1:0] SHOULDER_RST = 8'd90;
  localparam logic [AngleW-1:0] ELBOW_RST = 8'd45;

  localparam logic [7:0] SERVO_STEP_RST = 8'd4;
  localparam logic [6:0] RAMP_SMOOTH_RST = 7'd4;
  localparam logic [6:0] RAMP_NORMAL_RST = 7'd8;
  localparam logic [6:0] RAMP_AGGR_RST = 7'd20;

  typedef enum logic [1:0] {
    REG_SERVO_STEP  = 2'd0,
    REG_RAMP_SMOOTH = 2'd1,
    REG_RAMP_NORMAL = 2'd2,
    REG_RAMP_AGGR   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    PROF_SMOOTH = 2'd0,
    PROF_NORMAL = 2'd1,
    PROF_AGGR   = 2'd2,
    PROF_AGGR_ALT = 2'd3
  } prof_e;

  typedef enum logic [3:0] {
    DRV_HALT   = 4'd0,
    DRV_FWD    = 4'd1,
    DRV_BWD    = 4'd2,
    DRV_SPIN_L = 4'd3,
    DRV_SPIN_R = 4'd4,
    DRV_ARC_FL = 4'd5,
    DRV_ARC_FR = 4'd6,
    DRV_ARC_BL = 4'd7,
    DRV_ARC_BR = 4'd8
  } dir_e;

  typedef struct packed {
    logic [7:0] servo_step;
    logic [6:0] ramp_smooth;
    logic [6:0] ramp_normal;
    logic [6:0] ramp_aggr;
  } cfg_t;

  typedef struct packed {
    logic              powered;
    logic              fault;
    logic [3:0]        direction;
    logic [SpeedW-1:0] target_speed;
    logic [1:0]        profile;
    logic [AngleW-1:0] ls_goal;
    logic [AngleW-1:0] le_goal;
    logic [AngleW-1:0] rs_goal;
    logic [AngleW-1:0] re_goal;
  } item_t;

  typedef struct packed {
    logic [SpeedW-1:0] speed;
    logic [AngleW-1:0] ls;
    logic [AngleW-1:0] le;
    logic [AngleW-1:0] rs;
    logic [AngleW-1:0] re;
  } state_t;

  typedef struct packed {
    dir_e   dir;
    state_t st;
  } upd_t;

  typedef struct packed {
    logic [7:0][DutyW-1:0]  duty;
    logic [3:0][PulseW-1:0] pulse;
  } result_t;

  // Move cur toward goal by at most step; land on goal when within reach.
  function automatic logic [8:0] approach(logic [8:0] cur, logic [8:0] goal,
                                          logic [8:0] step);
    logic [8:0] res;
    res = cur;
    if (cur < goal) begin
      res = ((goal - cur) <= step) ? goal : cur + step;
    end else if (cur > goal) begin
      res = ((cur - goal) <= step) ? goal : cur - step;
    end
    return res;
  endfunction

  function automatic logic [AngleW-1:0] sat_angle(logic [AngleW-1:0] a);
    return (a > ANGLE_MAX) ? ANGLE_MAX : a;
  endfunction

endpackage

[design/drse_cfg.sv]
module drse_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  output drse_pkg::cfg_t     cfg_o
);

  drse_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (drse_pkg::reg_idx_e'(cfg_idx_i))
        drse_pkg::REG_SERVO_STEP:  cfg_d.servo_step  = cfg_data_i;
        drse_pkg::REG_RAMP_SMOOTH: cfg_d.ramp_smooth = cfg_data_i[6:0];
        drse_pkg::REG_RAMP_NORMAL: cfg_d.ramp_normal = cfg_data_i[6:0];
        drse_pkg::REG_RAMP_AGGR:   cfg_d.ramp_aggr   = cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.servo_step  <= drse_pkg::SERVO_STEP_RST;
      cfg_q.ramp_smooth <= drse_pkg::RAMP_SMOOTH_RST;
      cfg_q.ramp_normal <= drse_pkg::RAMP_NORMAL_RST;
      cfg_q.ramp_aggr   <= drse_pkg::RAMP_AGGR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/drse_track.sv]
module drse_track (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  drse_pkg::item_t   item_i,
  input  drse_pkg::cfg_t    cfg_i,
  output drse_pkg::state_t  state_o,
  output drse_pkg::upd_t    upd_o
);

  drse_pkg::state_t st_q, st_d;
  logic             active;
  drse_pkg::dir_e   dir_raw;
  drse_pkg::dir_e   dir_eff;
  logic [6:0]       tgt;
  logic [6:0]       desired;
  logic [6:0]       ramp;
  logic [8:0]       sstep;
  logic [8:0]       spd_next;

  assign active  = item_i.powered && !item_i.fault;
  assign dir_raw = drse_pkg::dir_e'(item_i.direction);
  assign dir_eff = (!active || (dir_raw > drse_pkg::DRV_ARC_BR)) ? drse_pkg::DRV_HALT
                                                                 : dir_raw;
  assign tgt     = (item_i.target_speed > drse_pkg::SPEED_MAX) ? drse_pkg::SPEED_MAX
                                                                : item_i.target_speed;
  assign desired = (dir_eff == drse_pkg::DRV_HALT) ? 7'd0 : tgt;
  assign sstep   = {1'b0, cfg_i.servo_step};

  always_comb begin
    case (drse_pkg::prof_e'(item_i.profile))
      drse_pkg::PROF_SMOOTH: ramp = cfg_i.ramp_smooth;
      drse_pkg::PROF_NORMAL: ramp = cfg_i.ramp_normal;
      default:               ramp = cfg_i.ramp_aggr;
    endcase
  end

  // Power off or fault: zero the speed outright.
  assign spd_next = drse_pkg::approach({2'b00, st_q.speed}, {2'b00, desired},
                                       {2'b00, ramp});

  always_comb begin
    st_d = st_q;
    st_d.speed = active ? spd_next[6:0] : 7'd0;
    if (active) begin
      st_d.ls = 8'(drse_pkg::approach({1'b0, st_q.ls},
                   {1'b0, drse_pkg::sat_angle(item_i.ls_goal)}, sstep));
      st_d.le = 8'(drse_pkg::approach({1'b0, st_q.le},
                   {1'b0, drse_pkg::sat_angle(item_i.le_goal)}, sstep));
      st_d.rs = 8'(drse_pkg::approach({1'b0, st_q.rs},
                   {1'b0, drse_pkg::sat_angle(item_i.rs_goal)}, sstep));
      st_d.re = 8'(drse_pkg::approach({1'b0, st_q.re},
                   {1'b0, drse_pkg::sat_angle(item_i.re_goal)}, sstep));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.speed <= drse_pkg::SPEED_RST;
      st_q.ls    <= drse_pkg::SHOULDER_RST;
      st_q.le    <= drse_pkg::ELBOW_RST;
      st_q.rs    <= drse_pkg::SHOULDER_RST;
      st_q.re    <= drse_pkg::ELBOW_RST;
    end else if (adv_i) begin
      st_q <= st_d;
    end
  end

  assign state_o   = st_q;
  assign upd_o.dir = dir_eff;
  assign upd_o.st  = st_d;

endmodule

[design/drse_mix.sv]
module drse_mix (
  input  drse_pkg::upd_t    upd_i,
  output drse_pkg::result_t res_o
);

  logic [27:0] duty_prod;
  logic [7:0]  s;
  logic [7:0]  h;
  logic [3:0][7:0]  ang;
  logic [3:0][27:0] pul_prod;
  logic [7:0][7:0]  duty;
  logic [3:0][11:0] pulse;

  assign duty_prod = 28'(upd_i.st.speed) * 28'(drse_pkg::DUTY_MUL);
  assign s = duty_prod[drse_pkg::DUTY_SHIFT +: 8];
  assign h = {1'b0, s[7:1]};

  assign ang = {upd_i.st.re, upd_i.st.rs, upd_i.st.le, upd_i.st.ls};

  for (genvar g = 0; g < 4; g++) begin : g_pulse
    assign pul_prod[g] = 28'(ang[g]) * 28'(drse_pkg::PULSE_MUL);
    assign pulse[g] = drse_pkg::PULSE_BASE + pul_prod[g][drse_pkg::PULSE_SHIFT +: 12];
  end

  // Duty order: m1 fwd, m1 rev, m2 fwd, m2 rev, m3 fwd, m3 rev, m4 fwd, m4 rev.
  always_comb begin
    duty = '0;
    case (upd_i.dir)
      drse_pkg::DRV_FWD: begin
        duty[0] = s; duty[2] = s; duty[4] = s; duty[6] = s;
      end
      drse_pkg::DRV_BWD: begin
        duty[1] = s; duty[3] = s; duty[5] = s; duty[7] = s;
      end
      drse_pkg::DRV_SPIN_L: begin
        duty[1] = s; duty[2] = s; duty[5] = s; duty[6] = s;
      end
      drse_pkg::DRV_SPIN_R: begin
        duty[0] = s; duty[3] = s; duty[4] = s; duty[7] = s;
      end
      drse_pkg::DRV_ARC_FL: begin
        duty[0] = h; duty[2] = s; duty[4] = h; duty[6] = s;
      end
      drse_pkg::DRV_ARC_FR: begin
        duty[0] = s; duty[2] = h; duty[4] = s; duty[6] = h;
      end
      drse_pkg::DRV_ARC_BL: begin
        duty[1] = h; duty[3] = s; duty[5] = h; duty[7] = s;
      end
      drse_pkg::DRV_ARC_BR: begin
        duty[1] = s; duty[3] = h; duty[5] = s; duty[7] = h;
      end
      default: ;
    endcase
  end

  assign res_o = {duty, pulse};

endmodule

[design/drive_ramp_and_servo_easing_top.sv]
// A transaction accepted into the input register moves on to the result register
// and is presented on the result port. Throughput: one transaction per cycle
// while the result port does not stall. While a result waits, one more tick is
// held in the input register; after that the input stalls until the result leaves.
// Reset (async, active low): speed 0, angles 90/45/90/45, steps 4/4/8/20,
// both pipeline stages empty.
`include "assert_macros.svh"

module drive_ramp_and_servo_easing_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // tick input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        powered_i,
  input  logic        fault_i,
  input  logic [3:0]  direction_i,
  input  logic [6:0]  target_speed_i,
  input  logic [1:0]  profile_i,
  input  logic [7:0]  left_shoulder_goal_i,
  input  logic [7:0]  left_elbow_goal_i,
  input  logic [7:0]  right_shoulder_goal_i,
  input  logic [7:0]  right_elbow_goal_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  m1_fwd_duty_o,
  output logic [7:0]  m1_rev_duty_o,
  output logic [7:0]  m2_fwd_duty_o,
  output logic [7:0]  m2_rev_duty_o,
  output logic [7:0]  m3_fwd_duty_o,
  output logic [7:0]  m3_rev_duty_o,
  output logic [7:0]  m4_fwd_duty_o,
  output logic [7:0]  m4_rev_duty_o,
  output logic [11:0] left_shoulder_pulse_o,
  output logic [11:0] left_elbow_pulse_o,
  output logic [11:0] right_shoulder_pulse_o,
  output logic [11:0] right_elbow_pulse_o
);

  drse_pkg::cfg_t    cfg;
  drse_pkg::item_t   in_item;
  drse_pkg::item_t   s1_item_q;
  drse_pkg::state_t  state;
  drse_pkg::upd_t    upd;
  drse_pkg::result_t res;
  drse_pkg::result_t out_res_q;
  logic              s1_valid_q, s1_valid_d;
  logic              out_valid_q, out_valid_d;
  logic              in_accept;
  logic              adv;

  // Pack the tick fields into one item word.
  assign in_item = '{
    powered:      powered_i,
    fault:        fault_i,
    direction:    direction_i,
    target_speed: target_speed_i,
    profile:      profile_i,
    ls_goal:      left_shoulder_goal_i,
    le_goal:      left_elbow_goal_i,
    rs_goal:      right_shoulder_goal_i,
    re_goal:      right_elbow_goal_i
  };

  // Advance the held tick into the result register whenever that register
  // is empty or its contents leave this cycle. The state registers update on
  // the same edge, so the next tick always sees the state this one leaves.
  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on transfer only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item;
    end
    if (adv) begin
      out_res_q <= res;
    end
  end

  drse_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Speed ramp and angle easing; holds the tick-to-tick state.
  drse_track u_track (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .item_i  (s1_item_q),
    .cfg_i   (cfg),
    .state_o (state),
    .upd_o   (upd)
  );

  // Direction mix to motor duties and angle to pulse width.
  drse_mix u_mix (
    .upd_i (upd),
    .res_o (res)
  );

  assign out_valid_o            = out_valid_q;
  assign m1_fwd_duty_o          = out_res_q.duty[0];
  assign m1_rev_duty_o          = out_res_q.duty[1];
  assign m2_fwd_duty_o          = out_res_q.duty[2];
  assign m2_rev_duty_o          = out_res_q.duty[3];
  assign m3_fwd_duty_o          = out_res_q.duty[4];
  assign m3_rev_duty_o          = out_res_q.duty[5];
  assign m4_fwd_duty_o          = out_res_q.duty[6];
  assign m4_rev_duty_o          = out_res_q.duty[7];
  assign left_shoulder_pulse_o  = out_res_q.pulse[0];
  assign left_elbow_pulse_o     = out_res_q.pulse[1];
  assign right_shoulder_pulse_o = out_res_q.pulse[2];
  assign right_elbow_pulse_o    = out_res_q.pulse[3];

  // Stall only while a tick is actually held.
  `ASSERT_AT(a_stall_needs_item, clk_i, rst_ni, in_stall_o |-> s1_valid_q, "stall without held tick")
  // Ramped speed never leaves 0..100.
  `ASSERT_NEVER(a_speed_range, clk_i, rst_ni, state.speed > drse_pkg::SPEED_MAX, "speed above 100")
  // An unpowered or faulted tick drives every motor duty to zero and clears the speed.
  `ASSERT_AT(a_inactive_zero, clk_i, rst_ni, (adv && !(s1_item_q.powered && !s1_item_q.fault)) |=> ((out_res_q.duty == '0) && (state.speed == '0)), "inactive tick left drive on")
  // A result taken with no tick advancing leaves the result register empty.
  `ASSERT_AT(a_out_drain, clk_i, rst_ni, (out_valid_q && !out_stall_i && !adv) |=> !out_valid_q, "result repeated")

endmodule
